// ===== sv/bhq_pkg.sv =====
// ---------------------------------------------------------------------------
// bhq_pkg: shared constants for the binary min-heap queue
// Default sizes, operation codes and result status codes.
// ---------------------------------------------------------------------------
`default_nettype none

package bhq_pkg;

	// Default sizes of the heap storage and of the entry fields.
	localparam int CAPACITY_DEF = 1023;
	localparam int KEY_BITS_DEF = 32;
	localparam int TAG_BITS_DEF = 16;

	// Width of the occupancy field on the result channel.
	localparam int OCC_BITS = 10;

	// Operation codes carried in the opcode field.
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== sv/binary_min_heap_queue_top.sv =====
// ---------------------------------------------------------------------------
// binary_min_heap_queue_top: binary min-heap priority queue
// Keyed entries with a tag, kept in one RAM as an array-based heap.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes one command per transfer:
// opcode insert stores in_key/in_tag, opcode extract removes the entry with
// the smallest key. Each command gives exactly one result on the output
// channel (out_valid/out_ready): out_key/out_tag of the extracted entry
// (zero otherwise), a status code and the occupancy after the command.
// Commands run one at a time. A refused command goes straight to its result.
// in_ready rises together with out_valid, so the next command can be taken
// while the result is shown. The sift steps are paced by the single RAM
// read port: sift up reads one parent per level, sift down reads two
// children.
// The result sits in an output register, so a new command is taken while
// the receiver stalls; that command finishes and then waits for the output
// register to empty. Reset empties the heap at once; the RAM is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue_top #(
	parameter int CAPACITY = bhq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = bhq_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = bhq_pkg::TAG_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          opcode,
	input  wire logic [KEY_BITS-1:0]           in_key,
	input  wire logic [TAG_BITS-1:0]           in_tag,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [KEY_BITS-1:0]           out_key,
	output logic      [TAG_BITS-1:0]           out_tag,
	output logic      [1:0]                    status,
	output logic      [bhq_pkg::OCC_BITS-1:0]  occupancy
);

	localparam int AW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_BITS + TAG_BITS;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_UP_CMP  = 8'b0000_0010,
		S_EX_ROOT = 8'b0000_0100,
		S_EX_LAST = 8'b0000_1000,
		S_DN_RD   = 8'b0001_0000,
		S_DN_CMP  = 8'b0010_0000,
		S_WB      = 8'b0100_0000,
		S_POST    = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       count_q;
	logic [AW-1:0]       pos_q;
	logic [EW-1:0]       cur_q;
	logic [EW-1:0]       left_q;
	logic                right_ok_q;
	logic [KEY_BITS-1:0] res_key_q;
	logic [TAG_BITS-1:0] res_tag_q;
	logic [1:0]          res_status_q;
	logic                out_valid_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [TAG_BITS-1:0] out_tag_q;
	logic [1:0]          out_status_q;
	logic [bhq_pkg::OCC_BITS-1:0] out_occ_q;

	// RAM ports.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	bhq_ram #(
		.DEPTH (CAPACITY + 1),
		.WIDTH (EW),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Index arithmetic and key compares shared by the sift steps.
	logic [KEY_BITS-1:0] rd_key;
	logic [KEY_BITS-1:0] cur_key;
	logic [KEY_BITS-1:0] left_key;
	logic [KEY_BITS-1:0] best_key;
	logic [AW-1:0]       parent;
	logic [AW-1:0]       new_pos;
	logic [AW:0]         cnt_ext;
	logic [AW:0]         lft;
	logic [AW:0]         rgt;
	logic [AW:0]         child_lft;
	logic [AW-1:0]       child_idx;
	logic [EW-1:0]       child_entry;
	logic                go_l;
	logic                go_r;
	logic                move;
	logic                in_fire;
	logic                is_full;

	always_comb begin
		rd_key      = ram_rdata[EW-1:TAG_BITS];
		cur_key     = cur_q[EW-1:TAG_BITS];
		left_key    = left_q[EW-1:TAG_BITS];
		parent      = pos_q >> 1;
		new_pos     = count_q + AW'(1);
		cnt_ext     = {1'b0, count_q};
		lft         = {pos_q, 1'b0};
		rgt         = lft + (AW+1)'(1);
		go_l        = left_key < cur_key;
		best_key    = go_l ? left_key : cur_key;
		go_r        = right_ok_q && (rd_key < best_key);
		move        = go_l || go_r;
		child_idx   = go_r ? rgt[AW-1:0] : lft[AW-1:0];
		child_entry = go_r ? ram_rdata : left_q;
		child_lft   = {child_idx, 1'b0};
		in_fire     = in_valid && in_ready;
		is_full     = count_q >= AW'(CAPACITY);
	end

	assign in_ready = (state_q == S_IDLE);

	// RAM access for each step of the sequencer.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = cur_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire && opcode == bhq_pkg::OP_INSERT) begin
					if (!is_full && new_pos != AW'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = new_pos >> 1;
					end
				end else if (in_fire && count_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(1);
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (!(rd_key < cur_key)) begin
					// The parent moves down into the hole.
					ram_wdata = ram_rdata;
					if (parent != AW'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = parent >> 1;
					end
				end
			end
			S_EX_ROOT: begin
				ram_re    = 1'b1;
				ram_raddr = count_q;
			end
			S_EX_LAST: begin
				if (count_q >= AW'(2)) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(2);
				end
			end
			S_DN_RD: begin
				if (rgt <= cnt_ext) begin
					ram_re    = 1'b1;
					ram_raddr = rgt[AW-1:0];
				end
			end
			S_DN_CMP: begin
				ram_we = 1'b1;
				if (move) begin
					// The smaller child moves up into the hole.
					ram_wdata = child_entry;
					if (child_lft <= cnt_ext) begin
						ram_re    = 1'b1;
						ram_raddr = child_lft[AW-1:0];
					end
				end
			end
			S_WB: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control sequencer: the moving entry stays in cur_q while the hole walks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A result leaving the output register; a new one is loaded in S_POST.
			if (out_ready && state_q != S_POST) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (opcode == bhq_pkg::OP_INSERT) begin
							if (is_full) begin
								state_q <= S_POST;
							end else begin
								count_q <= new_pos;
								state_q <= (new_pos == AW'(1)) ? S_WB : S_UP_CMP;
							end
						end else if (count_q == '0) begin
							state_q <= S_POST;
						end else begin
							state_q <= S_EX_ROOT;
						end
					end
				end
				S_UP_CMP: begin
					if (rd_key < cur_key) begin
						state_q <= S_POST;
					end else begin
						state_q <= (parent == AW'(1)) ? S_WB : S_UP_CMP;
					end
				end
				S_EX_ROOT: begin
					count_q <= count_q - AW'(1);
					state_q <= S_EX_LAST;
				end
				S_EX_LAST: begin
					if (count_q == '0) begin
						state_q <= S_POST;
					end else if (count_q >= AW'(2)) begin
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_WB;
					end
				end
				S_DN_RD: begin
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (move) begin
						state_q <= (child_lft <= cnt_ext) ? S_DN_RD : S_WB;
					end else begin
						state_q <= S_POST;
					end
				end
				S_WB: begin
					state_q <= S_POST;
				end
				S_POST: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: moving entry, hole position, result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_key_q <= '0;
				res_tag_q <= '0;
				pos_q     <= new_pos;
				cur_q     <= {in_key, in_tag};
				if (opcode == bhq_pkg::OP_INSERT) begin
					res_status_q <= is_full ? bhq_pkg::ST_FULL : bhq_pkg::ST_OK;
				end else begin
					res_status_q <= (count_q == '0) ? bhq_pkg::ST_EMPTY : bhq_pkg::ST_OK;
				end
			end
			S_UP_CMP: begin
				pos_q <= parent;
			end
			S_EX_ROOT: begin
				res_key_q <= rd_key;
				res_tag_q <= ram_rdata[TAG_BITS-1:0];
			end
			S_EX_LAST: begin
				cur_q <= ram_rdata;
				pos_q <= AW'(1);
			end
			S_DN_RD: begin
				left_q     <= ram_rdata;
				right_ok_q <= rgt <= cnt_ext;
			end
			S_DN_CMP: begin
				pos_q <= child_idx;
			end
			S_POST: begin
				if (!out_valid_q || out_ready) begin
					out_key_q    <= res_key_q;
					out_tag_q    <= res_tag_q;
					out_status_q <= res_status_q;
					out_occ_q    <= bhq_pkg::OCC_BITS'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign status    = out_status_q;
	assign occupancy = out_occ_q;

endmodule

`default_nettype wire

// ===== sv/bhq_ram.sv =====
// ---------------------------------------------------------------------------
// bhq_ram: heap entry storage
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module bhq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 48,
	parameter int AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking testbench for binary_min_heap_queue_top
// Sends insert and extract commands over the input channel and keeps a
// shadow heap that works out the result of each accepted command. Every
// result transfer is checked field by field, in order, against it. A short
// directed opening covers the empty and tie cases. Random traffic then
// fills the heap to capacity, pushes inserts against the full heap and
// drains it part way, while both channels idle in rotating patterns.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP   = bhq_pkg::CAPACITY_DEF;
	localparam int KEY_W = bhq_pkg::KEY_BITS_DEF;
	localparam int TAG_W = bhq_pkg::TAG_BITS_DEF;
	localparam int OCC_W = bhq_pkg::OCC_BITS;

	// One predicted result transfer.
	typedef struct {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [1:0]       st;
		logic [OCC_W-1:0] occ;
	} heap_result_t;

	// Shadow copy of the heap. Each accepted command is applied here and its
	// result is queued; result transfers are checked against the queue head.
	class heap_shadow;
		logic [KEY_W-1:0] keys [1:CAP];
		logic [TAG_W-1:0] tags [1:CAP];
		int unsigned      count;
		heap_result_t     due_results [$];
		int               errors;
		int               n_insert, n_full, n_extract, n_empty, n_checked, peak;

		function new();
			count = 0;
			errors = 0;
			n_insert = 0;
			n_full = 0;
			n_extract = 0;
			n_empty = 0;
			n_checked = 0;
			peak = 0;
		endfunction

		function void swap_slots(int unsigned p, int unsigned q);
			logic [KEY_W-1:0] tk;
			logic [TAG_W-1:0] tt;
			tk = keys[p];
			tt = tags[p];
			keys[p] = keys[q];
			tags[p] = tags[q];
			keys[q] = tk;
			tags[q] = tt;
		endfunction

		function void note_command(logic op, logic [KEY_W-1:0] key,
				logic [TAG_W-1:0] tag);
			heap_result_t res;
			int unsigned  pos, up, best, lc, rc;
			bit           moving;
			res.key = '0;
			res.tag = '0;
			res.st = bhq_pkg::ST_OK;
			if (op == bhq_pkg::OP_INSERT) begin
				n_insert++;
				if (count >= CAP) begin
					res.st = bhq_pkg::ST_FULL;
					n_full++;
				end else begin
					// Append, then rise while the parent key is not smaller.
					count++;
					keys[count] = key;
					tags[count] = tag;
					pos = count;
					moving = 1'b1;
					while (moving && pos > 1) begin
						up = pos / 2;
						if (keys[up] < keys[pos]) begin
							moving = 1'b0;
						end else begin
							swap_slots(up, pos);
							pos = up;
						end
					end
				end
			end else begin
				n_extract++;
				if (count == 0) begin
					res.st = bhq_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					// Take the root, move the last entry up and let it sink,
					// following the strictly smaller child, left on a tie.
					res.key = keys[1];
					res.tag = tags[1];
					swap_slots(1, count);
					count--;
					pos = 1;
					moving = 1'b1;
					while (moving) begin
						best = pos;
						lc = 2 * pos;
						rc = lc + 1;
						if (lc <= count && keys[lc] < keys[best])
							best = lc;
						if (rc <= count && keys[rc] < keys[best])
							best = rc;
						if (best == pos) begin
							moving = 1'b0;
						end else begin
							swap_slots(pos, best);
							pos = best;
						end
					end
				end
			end
			res.occ = count[OCC_W-1:0];
			if (count > peak)
				peak = count;
			due_results.push_back(res);
		endfunction

		function void check_result(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
				logic [1:0] st, logic [OCC_W-1:0] occ);
			heap_result_t exp_res;
			n_checked++;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("error: result with no command outstanding:",
						" key=%h tag=%h st=%0d occ=%0d", key, tag, st, occ);
			end else begin
				exp_res = due_results.pop_front();
				if (key !== exp_res.key || tag !== exp_res.tag || st !== exp_res.st ||
						occ !== exp_res.occ) begin
					errors++;
					if (errors <= 10)
						$display("error: result %0d expected key=%h tag=%h st=%0d occ=%0d,",
							n_checked, exp_res.key, exp_res.tag, exp_res.st, exp_res.occ,
							" got key=%h tag=%h st=%0d occ=%0d", key, tag, st, occ);
				end
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             opcode;
	logic [KEY_W-1:0] in_key;
	logic [TAG_W-1:0] in_tag;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [KEY_W-1:0] out_key;
	logic [TAG_W-1:0] out_tag;
	logic [1:0]       status;
	logic [OCC_W-1:0] occupancy;

	// Idle pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 both lightly.
	int          idle_mode = 0;
	int          items_sent = 0;
	heap_shadow  sb;

	binary_min_heap_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.in_key    (in_key),
		.in_tag    (in_tag),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_key   (out_key),
		.out_tag   (out_tag),
		.status    (status),
		.occupancy (occupancy)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check each transfer, then choose whether to stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_key, out_tag, status, occupancy);
		out_ready <= ($urandom_range(99) >= ((idle_mode == 2) ? 50 : (idle_mode == 3) ? 12 : 0));
	end

	// Hard limit on the run, well beyond the slowest passing run.
	initial begin
		#5_000_000;
		$display("error: run timed out");
		$display("status: fail");
		$finish;
	end

	// Key mix: half full range, many small keys to force ties, plus both ends.
	function automatic logic [KEY_W-1:0] pick_key();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: pick_key = raw[KEY_W-1:0];
			5, 6, 7:       pick_key = KEY_W'(raw[3:0]);
			8:             pick_key = raw[4] ? '1 : '0;
			default:       pick_key = ~KEY_W'(raw[3:0]);
		endcase
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		logic [31:0] raw;
		raw = $urandom;
		return raw[TAG_W-1:0];
	endfunction

	function automatic logic pick_op(int insert_pct);
		return ($urandom_range(99) < insert_pct) ? bhq_pkg::OP_INSERT : bhq_pkg::OP_EXTRACT;
	endfunction

	// Present one command and hold it until the transfer happens.
	task automatic send_cmd(input logic op, input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag);
		int gap_pct;
		idle_mode = (items_sent / 90) % 4;
		gap_pct = (idle_mode == 1) ? 50 : (idle_mode == 3) ? 12 : 0;
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		opcode <= op;
		in_key <= key;
		in_tag <= tag;
		do @(posedge clk); while (!in_ready);
		sb.note_command(op, key, tag);
		items_sent++;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = bhq_pkg::OP_INSERT;
		in_key = '0;
		in_tag = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extract from empty, both key extremes.
		send_cmd(bhq_pkg::OP_EXTRACT, '0, '0);
		send_cmd(bhq_pkg::OP_INSERT, '1, '1);
		send_cmd(bhq_pkg::OP_INSERT, '0, '0);
		send_cmd(bhq_pkg::OP_EXTRACT, '0, '0);
		send_cmd(bhq_pkg::OP_EXTRACT, '0, '0);
		send_cmd(bhq_pkg::OP_EXTRACT, '0, '0);

		// Directed: two equal children under a larger sinking entry.
		send_cmd(bhq_pkg::OP_INSERT, 32'd1, 16'h0011);
		send_cmd(bhq_pkg::OP_INSERT, 32'd2, 16'h00a1);
		send_cmd(bhq_pkg::OP_INSERT, 32'd2, 16'h00b2);
		send_cmd(bhq_pkg::OP_INSERT, 32'd9, 16'h0090);
		repeat (5) send_cmd(bhq_pkg::OP_EXTRACT, '0, '0);

		// Directed: equal keys rise past each other and do not sink.
		send_cmd(bhq_pkg::OP_INSERT, 32'd7, 16'h0701);
		send_cmd(bhq_pkg::OP_INSERT, 32'd7, 16'h0702);
		send_cmd(bhq_pkg::OP_INSERT, 32'd7, 16'h0703);
		send_cmd(bhq_pkg::OP_INSERT, 32'd7, 16'h0704);
		send_cmd(bhq_pkg::OP_EXTRACT, '0, '0);
		send_cmd(bhq_pkg::OP_EXTRACT, '0, '0);

		// Directed: single top bit against all lower bits.
		send_cmd(bhq_pkg::OP_INSERT, 32'h8000_0000, 16'h8000);
		send_cmd(bhq_pkg::OP_INSERT, 32'h7fff_ffff, 16'h7fff);
		repeat (3) send_cmd(bhq_pkg::OP_EXTRACT, '0, '0);

		// Mixed traffic around empty: refused extracts and shallow heaps.
		repeat (150) send_cmd(pick_op(50), pick_key(), pick_tag());

		// Fill to capacity with mostly inserts, deepening the sift-up paths.
		while (sb.count < CAP)
			send_cmd(pick_op(95), pick_key(), pick_tag());

		// Inserts against the full heap, then churn at the full mark.
		repeat (6) send_cmd(bhq_pkg::OP_INSERT, pick_key(), pick_tag());
		repeat (40) send_cmd(pick_op(50), pick_key(), pick_tag());

		// Drain part way with long sift-down paths.
		repeat (100) send_cmd(pick_op(20), pick_key(), pick_tag());

		in_valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d commands: %0d inserts (%0d refused full),",
			items_sent, sb.n_insert, sb.n_full,
			" %0d extracts (%0d refused empty)", sb.n_extract, sb.n_empty);
		$display("checked %0d results, peak occupancy %0d, %0d errors",
			sb.n_checked, sb.peak, sb.errors);
		if (sb.errors == 0 && sb.due_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/bhq_pkg.sv
sv/bhq_ram.sv
sv/binary_min_heap_queue_top.sv
dv/tb.sv
